// ===== hw/rtl/dscu_pkg.sv =====
// Shared types, constants and calendar helper functions for the day serial calendar unit.
package dscu_pkg;

	localparam int unsigned BASE_YEAR   = 1870;
	localparam int unsigned LAST_YEAR   = 9999;
	localparam int unsigned QUAD_DAYS   = 365 * 4 + 1;
	localparam int unsigned LAST_SERIAL = (LAST_YEAR - BASE_YEAR) * 365
		+ (LAST_YEAR - BASE_YEAR + 1) / 4 + 365;

	localparam int unsigned SERIAL_W = 22;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned ALU_W    = 24;
	localparam int unsigned QUO_W    = 14;

	// ceil(2^32 / 1461), exact for any 22-bit dividend
	localparam int unsigned RECIP_QUAD     = 2939745;
	localparam int unsigned RECIP_QUAD_SH  = 32;
	// ceil(2^17 / 3), exact for any 16-bit dividend
	localparam int unsigned RECIP_THIRD    = 43691;
	localparam int unsigned RECIP_THIRD_SH = 17;

	typedef enum logic [2:0] {
		ACT_COMPOSE    = 3'd0,
		ACT_DECOMPOSE  = 3'd1,
		ACT_ADD_MONTHS = 3'd2,
		ACT_SUB_MONTHS = 3'd3,
		ACT_ADD_YEARS  = 3'd4,
		ACT_SUB_YEARS  = 3'd5
	} dscu_action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2
	} dscu_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_DREM,
		S_YEAR,
		S_MONTH,
		S_STEP,
		S_MEND,
		S_SER_MUL,
		S_SER_ADD,
		S_DONE
	} dscu_state_t;

	typedef struct packed {
		logic [2:0]          action;
		logic [5:0]          in_day;
		logic [3:0]          in_month;
		logic [YEAR_W-1:0]   in_year;
		logic [SERIAL_W-1:0] in_serial;
		logic [COUNT_W-1:0]  step_count;
	} dscu_req_t;

	typedef struct packed {
		logic [SERIAL_W-1:0] serial;
		logic [4:0]          day;
		logic [3:0]          month;
		logic [YEAR_W-1:0]   year;
		dscu_status_t        status;
	} dscu_res_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             ge;
		logic             gt;
	} dscu_alu_res_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00);
	endfunction

	// m is 1..12
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// m is 1..12
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] db;
		case (m)
			4'd1:    db = 9'd0;
			4'd2:    db = 9'd31;
			4'd3:    db = 9'd59;
			4'd4:    db = 9'd90;
			4'd5:    db = 9'd120;
			4'd6:    db = 9'd151;
			4'd7:    db = 9'd181;
			4'd8:    db = 9'd212;
			4'd9:    db = 9'd243;
			4'd10:   db = 9'd273;
			4'd11:   db = 9'd304;
			4'd12:   db = 9'd334;
			default: db = 9'd0;
		endcase
		return db;
	endfunction

endpackage

// ===== hw/rtl/dscu_if.sv =====
// Valid/ready channel interfaces for request and result beats.
interface dscu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [5:0]  in_day;
	logic [3:0]  in_month;
	logic [13:0] in_year;
	logic [21:0] in_serial;
	logic [15:0] step_count;

	modport source (output valid, action, in_day, in_month, in_year, in_serial,
		step_count, input ready);
	modport sink (input valid, action, in_day, in_month, in_year, in_serial,
		step_count, output ready);
endinterface

interface dscu_out_if;
	logic        valid;
	logic        ready;
	logic [21:0] out_serial;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [13:0] out_year;
	logic [1:0]  status;

	modport source (output valid, out_serial, out_day, out_month, out_year, status,
		input ready);
	modport sink (input valid, out_serial, out_day, out_month, out_year, status,
		output ready);
endinterface

// ===== hw/rtl/dscu_alu.sv =====
// Shared subtract/compare unit used by the remainder, year-walk, month-walk and step states of the sequencer.
module dscu_alu (
	input  logic [dscu_pkg::ALU_W-1:0] a,
	input  logic [dscu_pkg::ALU_W-1:0] b,
	output dscu_pkg::dscu_alu_res_t    res
);
	import dscu_pkg::*;

	logic [ALU_W:0] wide;

	assign wide     = {1'b0, a} - {1'b0, b};
	assign res.diff = wide[ALU_W-1:0];
	assign res.ge   = ~wide[ALU_W];
	assign res.gt   = ~wide[ALU_W] & (wide[ALU_W-1:0] != '0);
endmodule

// ===== hw/rtl/dscu_seq.sv =====
// Sequencer and datapath registers: divide, year/month walk, stepping and serial build.
module dscu_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dscu_pkg::dscu_req_t req,
	output logic                idle,
	output logic                done,
	input  logic                ack,
	output dscu_pkg::dscu_res_t res
);
	import dscu_pkg::*;

	dscu_state_t state_q, state_d;

	logic [2:0]          act_q, act_d;
	logic [COUNT_W-1:0]  cnt_q, cnt_d;
	logic [5:0]          d_q, d_d;
	logic [3:0]          m_q, m_d;
	logic [YEAR_W-1:0]   y_q, y_d;
	logic [ALU_W-1:0]    rem_q, rem_d;
	logic [QUO_W-1:0]    quo_q, quo_d;
	logic                div12_q, div12_d;
	logic                eom_q, eom_d;
	logic [SERIAL_W-1:0] ser_q, ser_d;
	logic [SERIAL_W-1:0] prod_q, prod_d;
	dscu_res_t           res_q, res_d;

	logic [ALU_W-1:0] alu_a, alu_b;
	dscu_alu_res_t    alu_res;

	logic [12:0]         ydiff;
	logic [16:0]         idx0;
	logic [17:0]         idx_add;
	logic [16:0]         ny_sum;
	logic [YEAR_W-1:0]   ny_step;
	logic [14:0]         nyw;
	logic [3:0]          nm;
	logic [4:0]          nlen;
	logic [SERIAL_W-1:0] ser_sum;
	logic [43:0]         quad_prod;
	logic [31:0]         third_prod;
	logic [QUO_W-1:0]    div_quo;

	dscu_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign ydiff     = 13'(y_q - YEAR_W'(BASE_YEAR));
	assign idx0      = 17'({ydiff, 3'b000}) + 17'({ydiff, 2'b00}) + 17'(m_q - 4'd1);
	assign idx_add   = 18'(idx0) + 18'(cnt_q);
	assign ny_sum    = 17'(y_q) + 17'(cnt_q);
	assign ny_step   = (act_q == ACT_ADD_YEARS) ? ny_sum[YEAR_W-1:0] : y_q - cnt_q[YEAR_W-1:0];
	assign nyw       = 15'(BASE_YEAR) + 15'(quo_q);
	assign nm        = rem_q[3:0] + 4'd1;
	assign nlen      = month_len(nm, is_leap(nyw[YEAR_W-1:0]));
	assign ser_sum   = prod_q
		+ SERIAL_W'((y_q - YEAR_W'(BASE_YEAR - 1)) >> 2)
		+ SERIAL_W'(days_before(m_q))
		+ SERIAL_W'(d_q)
		+ SERIAL_W'(is_leap(y_q) && (m_q > 4'd2));

	// divide by 1461 by reciprocal multiply, and by 12 as (x >> 2) / 3
	assign quad_prod  = 44'(rem_q[SERIAL_W-1:0]) * 44'(RECIP_QUAD);
	assign third_prod = 32'(rem_q[17:2]) * 32'(RECIP_THIRD);
	assign div_quo    = div12_q ? QUO_W'(third_prod >> RECIP_THIRD_SH)
		: QUO_W'(quad_prod >> RECIP_QUAD_SH);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_DREM: begin
				alu_a = rem_q;
				alu_b = div12_q ? ALU_W'(quo_q) * ALU_W'(12)
					: ALU_W'(quo_q) * ALU_W'(QUAD_DAYS);
			end
			S_YEAR: begin
				alu_a = rem_q;
				alu_b = ALU_W'(365) + ALU_W'(is_leap(y_q));
			end
			S_MONTH: begin
				alu_a = rem_q;
				alu_b = ALU_W'(month_len(m_q, is_leap(y_q)));
			end
			S_STEP: begin
				if (act_q == ACT_SUB_MONTHS) begin
					alu_a = ALU_W'(idx0);
				end else begin
					alu_a = ALU_W'(ydiff);
				end
				alu_b = ALU_W'(cnt_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		act_d   = act_q;
		cnt_d   = cnt_q;
		d_d     = d_q;
		m_d     = m_q;
		y_d     = y_q;
		rem_d   = rem_q;
		quo_d   = quo_q;
		div12_d = div12_q;
		eom_d   = eom_q;
		ser_d   = ser_q;
		prod_d  = prod_q;
		res_d   = res_q;
		idle    = 1'b0;
		done    = 1'b0;

		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					act_d   = req.action;
					cnt_d   = req.step_count;
					d_d     = req.in_day;
					m_d     = req.in_month;
					y_d     = req.in_year;
					ser_d   = req.in_serial;
					rem_d   = ALU_W'(req.in_serial);
					quo_d   = '0;
					div12_d = 1'b0;
					res_d   = '{serial: '0, day: '0, month: '0, year: '0, status: ST_INVALID};
					if (req.action > ACT_SUB_YEARS) begin
						state_d = S_DONE;
					end else if (req.action == ACT_COMPOSE) begin
						if (req.in_month < 4'd1 || req.in_month > 4'd12 ||
							req.in_day < 6'd1 || req.in_day > 6'd31 ||
							req.in_year < YEAR_W'(BASE_YEAR) ||
							req.in_year > YEAR_W'(LAST_YEAR)) begin
							state_d = S_DONE;
						end else begin
							state_d = S_SER_MUL;
						end
					end else if (req.in_serial <= SERIAL_W'(1)) begin
						res_d.status = ST_EMPTY;
						state_d      = S_DONE;
					end else if (req.in_serial > SERIAL_W'(LAST_SERIAL)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_DIV;
					end
				end
			end

			// quotient by reciprocal multiply, remainder on the shared subtractor
			S_DIV: begin
				quo_d   = div_quo;
				state_d = S_DREM;
			end

			S_DREM: begin
				rem_d   = alu_res.diff;
				state_d = div12_q ? S_MEND : S_YEAR;
				if (!div12_q) begin
					y_d = YEAR_W'(BASE_YEAR) + {quo_q[11:0], 2'b00};
				end
			end

			S_YEAR: begin
				if (alu_res.gt) begin
					rem_d = alu_res.diff;
					y_d   = y_q + YEAR_W'(1);
				end else begin
					if (rem_q == '0) begin
						y_d   = y_q - YEAR_W'(1);
						rem_d = ALU_W'(365);
					end
					m_d     = 4'd1;
					state_d = S_MONTH;
				end
			end

			S_MONTH: begin
				if (m_q < 4'd12 && alu_res.gt) begin
					rem_d = alu_res.diff;
					m_d   = m_q + 4'd1;
				end else begin
					d_d = rem_q[5:0];
					if (act_q == ACT_COMPOSE || act_q == ACT_DECOMPOSE) begin
						res_d   = '{serial: ser_q, day: rem_q[4:0], month: m_q,
							year: y_q, status: ST_OK};
						state_d = S_DONE;
					end else begin
						state_d = S_STEP;
					end
				end
			end

			S_STEP: begin
				eom_d   = (d_q == 6'(month_len(m_q, is_leap(y_q))));
				quo_d   = '0;
				div12_d = 1'b1;
				case (act_q)
					ACT_ADD_MONTHS: begin
						rem_d   = ALU_W'(idx_add);
						state_d = S_DIV;
					end
					ACT_SUB_MONTHS: begin
						rem_d   = alu_res.diff;
						state_d = alu_res.ge ? S_DIV : S_DONE;
					end
					ACT_ADD_YEARS, ACT_SUB_YEARS: begin
						if ((act_q == ACT_ADD_YEARS && ny_sum > 17'(LAST_YEAR)) ||
							(act_q == ACT_SUB_YEARS && !alu_res.ge)) begin
							state_d = S_DONE;
						end else begin
							y_d     = ny_step;
							state_d = S_SER_MUL;
							if (m_q == 4'd2 && d_q == 6'd29 && !is_leap(ny_step)) begin
								d_d = 6'd1;
								m_d = 4'd3;
							end
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_MEND: begin
				if (nyw > 15'(LAST_YEAR)) begin
					state_d = S_DONE;
				end else begin
					y_d = nyw[YEAR_W-1:0];
					m_d = nm;
					if (eom_q || d_q >= 6'(nlen)) begin
						d_d = 6'(nlen);
					end
					state_d = S_SER_MUL;
				end
			end

			S_SER_MUL: begin
				prod_d  = SERIAL_W'(ydiff) * SERIAL_W'(365);
				state_d = S_SER_ADD;
			end

			S_SER_ADD: begin
				ser_d = ser_sum;
				if (ser_sum <= SERIAL_W'(1)) begin
					res_d.status = ST_EMPTY;
					state_d      = S_DONE;
				end else if (act_q == ACT_COMPOSE) begin
					rem_d   = ALU_W'(ser_sum);
					quo_d   = '0;
					div12_d = 1'b0;
					state_d = S_DIV;
				end else begin
					res_d   = '{serial: ser_sum, day: d_q[4:0], month: m_q,
						year: y_q, status: ST_OK};
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				done = 1'b1;
				if (ack) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q   <= act_d;
		cnt_q   <= cnt_d;
		d_q     <= d_d;
		m_q     <= m_d;
		y_q     <= y_d;
		rem_q   <= rem_d;
		quo_q   <= quo_d;
		div12_q <= div12_d;
		eom_q   <= eom_d;
		ser_q   <= ser_d;
		prod_q  <= prod_d;
		res_q   <= res_d;
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/day_serial_calendar_unit_core.sv =====
// Top level of the day serial calendar unit: handshakes, sequencer and result register.
// One request at a time; ready only while the sequencer is idle, so a new request is
// taken only after the previous result has been loaded into the output register.
// Requests rejected on entry go straight to the result; decompose, compose, year steps
// and month steps use reciprocal divides (quotient, then remainder) plus up to 4 year
// and 12 month walk steps; later range failures end the operation early.
// Reset clears the sequencer state and the result valid flag; no clearing pass.
module day_serial_calendar_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	dscu_in_if.sink    in_bus,
	dscu_out_if.source out_bus
);
	import dscu_pkg::*;

	dscu_req_t req;
	dscu_res_t seq_res;
	dscu_res_t out_res_q;
	logic      out_valid_q;
	logic      seq_idle;
	logic      seq_done;
	logic      take;

	assign req = '{action: in_bus.action, in_day: in_bus.in_day, in_month: in_bus.in_month,
		in_year: in_bus.in_year, in_serial: in_bus.in_serial,
		step_count: in_bus.step_count};

	assign in_bus.ready = seq_idle;

	dscu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_bus.valid && seq_idle),
		.req    (req),
		.idle   (seq_idle),
		.done   (seq_done),
		.ack    (take),
		.res    (seq_res)
	);

	// load the result beat when the output slot is free or draining
	assign take = seq_done && (!out_valid_q || out_bus.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_bus.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_res_q <= seq_res;
		end
	end

	assign out_bus.valid      = out_valid_q;
	assign out_bus.out_serial = out_res_q.serial;
	assign out_bus.out_day    = out_res_q.day;
	assign out_bus.out_month  = out_res_q.month;
	assign out_bus.out_year   = out_res_q.year;
	assign out_bus.status     = out_res_q.status;

endmodule
